FILE: rtl/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

  // Sample format: unsigned fixed point with this many fraction bits.
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned ESC_W     = 16 + FRAC_BITS;

  // Palette geometry.
  localparam int unsigned PAL_ENTRIES = 16;
  localparam int unsigned PAL_IDX_W   = $clog2(PAL_ENTRIES);

  // The divide by six is a halving followed by a reciprocal multiply by three.
  // This is exact for every dividend below 2^(ESC_W - 1).
  localparam int unsigned HALF_W    = ESC_W - 1;
  localparam int unsigned DIV_SHIFT = ESC_W;
  localparam logic [HALF_W-1:0] DIV3_MUL = HALF_W'(((64'd1 << DIV_SHIFT) + 64'd2) / 64'd3);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PIXEL = CFG_IDX_W'(1);
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [15:0] MAX_ITER_RESET = 16'd1024;
  localparam logic [7:0]  SPP_RESET      = 8'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb8_t;

  // Gradient palette.
  function automatic rgb8_t palette_color(input logic [PAL_IDX_W-1:0] idx);
    rgb8_t c;
    unique case (idx)
      4'd0:    c = '{8'h07, 8'h00, 8'h5D};
      4'd1:    c = '{8'h11, 8'h19, 8'h87};
      4'd2:    c = '{8'h1E, 8'h4A, 8'hAC};
      4'd3:    c = '{8'h43, 8'h76, 8'hCD};
      4'd4:    c = '{8'h86, 8'hAF, 8'hE1};
      4'd5:    c = '{8'hD0, 8'hE8, 8'hF7};
      4'd6:    c = '{8'hED, 8'hE7, 8'hBE};
      4'd7:    c = '{8'hF5, 8'hC9, 8'h5A};
      4'd8:    c = '{8'hFD, 8'hA8, 8'h01};
      4'd9:    c = '{8'hC8, 8'h81, 8'h01};
      4'd10:   c = '{8'h94, 8'h54, 8'h00};
      4'd11:   c = '{8'h64, 8'h31, 8'h01};
      4'd12:   c = '{8'h42, 8'h12, 8'h06};
      4'd13:   c = '{8'h0E, 8'h03, 8'h0E};
      4'd14:   c = '{8'h05, 8'h00, 8'h26};
      default: c = '{8'h05, 8'h00, 8'h47};
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/palette_lerp_pixel_shader_unit.sv
`timescale 1ns / 1ps
// Path: a sample taken into the input register passes the divide and blend registers and reaches
// the output register when it closes a pixel.
// Throughput: one sample per cycle through a four-register pipeline (input, divide,
// blend, accumulate/output); the output register stalls the pipeline only while it is full,
// not being taken, and the next sample closes another pixel.
// Reset: asynchronous, active low; clears all valids, the running color and sample count,
// and loads max_iterations = 1024 and samples_per_pixel = 1.
module palette_lerp_pixel_shader_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pls_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pls_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pls_pkg::ESC_W-1:0]           escape_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [7:0]                          red_o,
  output logic [7:0]                          green_o,
  output logic [7:0]                          blue_o
);

  localparam int unsigned QW = pls_pkg::FRAC_BITS + pls_pkg::PAL_IDX_W;
  localparam int unsigned PW = 2 * pls_pkg::HALF_W;
  localparam int unsigned MW = 2 * 8 + 1;

  // Configuration registers.
  logic [15:0] max_iter_q;
  logic [7:0]  spp_q;

  // Pipeline registers.
  logic                       s1_valid_q, s2_valid_q, s3_valid_q;
  logic [pls_pkg::ESC_W-1:0]  s1_esc_q;
  logic [QW-1:0]              s2_q_q, s2_q_d;
  logic                       s2_black_q, s2_black_d;
  pls_pkg::rgb8_t             s3_color_q, s3_color_d;

  // Accumulator and output registers.
  pls_pkg::rgb8_t running_q, running_d;
  logic [7:0]     count_q, count_d;
  logic           out_valid_q;
  pls_pkg::rgb8_t out_q;

  logic s1_ready, s2_ready, s3_ready, out_free, emit, acc_fire;
  logic [PW-1:0] prod;
  logic [7:0]    limit;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Elastic pipeline control: a stage takes new data when it is empty or moves on.
  assign out_free = !out_valid_q || out_ready_i;
  assign acc_fire = s3_valid_q && (!emit || out_free);
  assign s3_ready = !s3_valid_q || acc_fire;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Stage 1: divide by six through a reciprocal multiply and test the iteration limit.
  assign prod       = PW'(s1_esc_q[pls_pkg::ESC_W-1:1]) * PW'(pls_pkg::DIV3_MUL);
  assign s2_q_d     = prod[pls_pkg::DIV_SHIFT +: QW];
  assign s2_black_d = s1_esc_q >= {max_iter_q, {pls_pkg::FRAC_BITS{1'b0}}};

  // Linear blend of one channel between two palette entries.
  function automatic logic [7:0] blend(input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [pls_pkg::FRAC_BITS-1:0] f);
    logic [MW-1:0] w0;
    logic [MW-1:0] sum;
    w0  = MW'(1 << pls_pkg::FRAC_BITS) - MW'(f);
    sum = MW'(c0) * w0 + MW'(c1) * MW'(f);
    return sum[pls_pkg::FRAC_BITS +: 8];
  endfunction

  // Stage 2: palette lookup and blend toward the next entry, which wraps around; black past the iteration limit.
  always_comb begin
    logic [pls_pkg::PAL_IDX_W-1:0] idx;
    logic [pls_pkg::FRAC_BITS-1:0] frac;
    pls_pkg::rgb8_t c0, c1;
    idx  = s2_q_q[pls_pkg::FRAC_BITS +: pls_pkg::PAL_IDX_W];
    frac = s2_q_q[pls_pkg::FRAC_BITS-1:0];
    c0   = pls_pkg::palette_color(idx);
    c1   = pls_pkg::palette_color(idx + 1'b1);
    if (s2_black_q) begin
      s3_color_d = '0;
    end else begin
      s3_color_d.red   = blend(c0.red,   c1.red,   frac);
      s3_color_d.green = blend(c0.green, c1.green, frac);
      s3_color_d.blue  = blend(c0.blue,  c1.blue,  frac);
    end
  end

  // Stage 3: pairwise averaging and pixel completion.
  assign limit = (spp_q == 8'd0) ? 8'd1 : spp_q;

  always_comb begin
    logic [8:0] r_sum, g_sum, b_sum;
    logic [7:0] cnt_inc;
    r_sum   = 9'(running_q.red)   + 9'(s3_color_q.red);
    g_sum   = 9'(running_q.green) + 9'(s3_color_q.green);
    b_sum   = 9'(running_q.blue)  + 9'(s3_color_q.blue);
    cnt_inc = count_q + 8'd1;
    if (count_q == 8'd0) begin
      running_d = s3_color_q;
    end else begin
      running_d = '{r_sum[8:1], g_sum[8:1], b_sum[8:1]};
    end
    emit    = (cnt_inc >= limit) || (cnt_inc == 8'd0);
    count_d = emit ? 8'd0 : cnt_inc;
  end

  // Control and configuration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q  <= pls_pkg::MAX_ITER_RESET;
      spp_q       <= pls_pkg::SPP_RESET;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      running_q   <= '0;
      count_q     <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == pls_pkg::CFG_MAX_ITERATIONS) begin
          max_iter_q <= cfg_data_i[15:0];
        end else if (cfg_index_i == pls_pkg::CFG_SAMPLES_PER_PIXEL) begin
          spp_q <= cfg_data_i[7:0];
        end
      end
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_valid_q;
      end
      if (acc_fire) begin
        running_q <= running_d;
        count_q   <= count_d;
      end
      if (acc_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_esc_q <= escape_value_i;
    end
    if (s2_ready) begin
      s2_q_q     <= s2_q_d;
      s2_black_q <= s2_black_d;
    end
    if (s3_ready) begin
      s3_color_q <= s3_color_d;
    end
    if (acc_fire && emit) begin
      out_q <= running_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_q.red;
  assign green_o     = out_q.green;
  assign blue_o      = out_q.blue;

endmodule

FILE: rtl/pls_checker.sv
`timescale 1ns / 1ps
module pls_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [7:0]                     red_o,
  input logic [7:0]                     green_o,
  input logic [7:0]                     blue_o
);

  // A pending result request stays valid until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped before it was taken");

  // A stalled result keeps its color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o))
    else $error("stalled result changed");

  // Input back-pressure only comes from a full, stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while the output could drain");

  // No result is offered right after reset.
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result offered out of reset");

endmodule

bind palette_lerp_pixel_shader_unit pls_checker u_pls_checker (.*);
